// ===== rtl/gaussian_weight_map_eval_unit_defines.svh =====
// Assertion macros for the Gaussian weight map evaluator.
// Included by the top level; the bodies fall away when SYNTHESIS is defined.
`ifndef GAUSSIAN_WEIGHT_MAP_EVAL_UNIT_DEFINES_SVH
`define GAUSSIAN_WEIGHT_MAP_EVAL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define GWM_ASSERT(name, expr) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("gwm: check failed");
`define GWM_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gwm: check failed");
`else
`define GWM_ASSERT(name, expr)
`define GWM_ASSERT_IMPLY(name, ante, cons)
`endif

`endif

// ===== rtl/gwm_pkg.sv =====
// Shared types and constants of the Gaussian weight map evaluator.
// Used by gwm_exp_pipe and gaussian_weight_map_eval_unit; depends on nothing.
package gwm_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_GRID_WIDTH  = 3'd2,
        CFG_GRID_HEIGHT = 3'd3,
        CFG_SPREAD_X    = 3'd4,
        CFG_SPREAD_Y    = 3'd5,
        CFG_PEAK_SCALE  = 3'd6,
        CFG_VALLEY_MODE = 3'd7
    } t_cfg_idx;

    localparam int unsigned DATA_W = 32;
    localparam logic [DATA_W-1:0] RST_SPREAD = 32'h0100_0000;  // 1.0 in Q8.24
    localparam logic [DATA_W-1:0] RST_PEAK   = 32'h0001_0000;  // 1.0 in Q16.16

    // exponent: t >= 12.0 (Q8.24) gives zero
    localparam logic [27:0] T_LIMIT = 28'hC00_0000;

    localparam int unsigned U_W          = 32;
    localparam int unsigned E_W          = 17;
    localparam int unsigned SERIES_TERMS = 12;
    localparam int unsigned SQUARINGS    = 4;
    localparam logic [E_W-1:0] E_MAX     = 17'h1_0000;

    typedef struct packed {
        logic on_grid;  // point lies on the grid
        logic big;      // exponent at or above the cutoff
    } t_exp_tag;

endpackage

// ===== rtl/gwm_exp_pipe.sv =====
// Pipelined E = round(65536 * e^(-u/2^32 * 16)) from a Q0.32 argument.
// Taylor series to the twelfth term, then four squarings; uses gwm_pkg.
module gwm_exp_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [gwm_pkg::U_W-1:0]       i_u,
    input  gwm_pkg::t_exp_tag             i_tag,
    output logic                          o_valid,
    output logic [gwm_pkg::E_W-1:0]       o_e,
    output gwm_pkg::t_exp_tag             o_tag
);

    localparam int unsigned NSTEP = gwm_pkg::SERIES_TERMS - 1;
    localparam int unsigned NSQ   = gwm_pkg::SQUARINGS;

    // series boundaries: index 0 holds the first term, index NSTEP the full sum
    logic                       r_v    [NSTEP+1];
    logic [31:0]                r_term [NSTEP+1];
    logic [32:0]                r_sum  [NSTEP+1];
    logic [gwm_pkg::U_W-1:0]    r_u    [NSTEP+1];
    gwm_pkg::t_exp_tag          r_tag  [NSTEP+1];

    // entry: term1 = u, sum = 1 - u
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term[0] <= i_u;
            r_sum[0]  <= 33'h1_0000_0000 - {1'b0, i_u};
            r_u[0]    <= i_u;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar j = 0; j < NSTEP; j++) begin : g_term
        localparam int K = j + 2;
        localparam logic [32:0] RECIP  = 33'((64'd1 << 33) / K);
        localparam logic [3:0]  KV     = 4'(K);
        localparam bit          SUBTR  = (K % 2) == 1;

        logic                    r_a_v, r_b_v;
        logic [31:0]             r_a_x, r_b_x, r_b_q0;
        logic [gwm_pkg::U_W-1:0] r_a_u, r_b_u;
        logic [32:0]             r_a_sum, r_b_sum;
        gwm_pkg::t_exp_tag       r_a_tag, r_b_tag;

        logic [63:0] w_a_prod;
        logic [64:0] w_b_prod;
        logic [35:0] w_c_qk;
        logic [35:0] w_c_rem;
        logic [31:0] w_c_q;
        logic [32:0] w_c_sum;

        assign w_a_prod = {32'd0, r_term[j]} * {32'd0, r_u[j]};
        assign w_b_prod = {33'd0, r_a_x} * {32'd0, RECIP};

        // reciprocal quotient is low by at most one: fix with one compare
        assign w_c_qk  = {4'd0, r_b_q0} * {32'd0, KV};
        assign w_c_rem = {4'd0, r_b_x} - w_c_qk;
        assign w_c_q   = (w_c_rem >= 36'(K)) ? r_b_q0 + 32'd1 : r_b_q0;
        assign w_c_sum = SUBTR ? r_b_sum - {1'b0, w_c_q} : r_b_sum + {1'b0, w_c_q};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_v    <= 1'b0;
                r_b_v    <= 1'b0;
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_a_v    <= r_v[j];
                r_b_v    <= r_a_v;
                r_v[j+1] <= r_b_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_x      <= w_a_prod[63:32];
                r_a_u      <= r_u[j];
                r_a_sum    <= r_sum[j];
                r_a_tag    <= r_tag[j];
                r_b_q0     <= w_b_prod[64:33];
                r_b_x      <= r_a_x;
                r_b_u      <= r_a_u;
                r_b_sum    <= r_a_sum;
                r_b_tag    <= r_a_tag;
                r_term[j+1] <= w_c_q;
                r_sum[j+1]  <= w_c_sum;
                r_u[j+1]    <= r_b_u;
                r_tag[j+1]  <= r_b_tag;
            end
        end
    end

    // squaring chain: p[0] = (S+1)/2 in Q1.31, then p = p^2 rounded, four times
    logic              r_pv   [NSQ+1];
    logic [31:0]       r_p    [NSQ+1];
    gwm_pkg::t_exp_tag r_ptag [NSQ+1];
    logic [33:0]       w_p0;

    assign w_p0 = {1'b0, r_sum[NSTEP]} + 34'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv[0] <= 1'b0;
        end else if (i_en) begin
            r_pv[0] <= r_v[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]    <= w_p0[32:1];
            r_ptag[0] <= r_tag[NSTEP];
        end
    end

    for (genvar s = 0; s < NSQ; s++) begin : g_square
        logic [63:0] w_sq;

        assign w_sq = {32'd0, r_p[s]} * {32'd0, r_p[s]} + 64'h4000_0000;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv[s+1] <= 1'b0;
            end else if (i_en) begin
                r_pv[s+1] <= r_pv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[s+1]    <= w_sq[62:31];
                r_ptag[s+1] <= r_ptag[s];
            end
        end
    end

    // round to Q1.16; drop to zero past the cutoff
    logic                    r_ev;
    logic [gwm_pkg::E_W-1:0] r_e;
    gwm_pkg::t_exp_tag       r_etag;
    logic [32:0]             w_e_sum;

    assign w_e_sum = {1'b0, r_p[NSQ]} + 33'h4000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else if (i_en) begin
            r_ev <= r_pv[NSQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e    <= r_ptag[NSQ].big ? '0 : w_e_sum[31:15];
            r_etag <= r_ptag[NSQ];
        end
    end

    assign o_valid = r_ev;
    assign o_e     = r_e;
    assign o_tag   = r_etag;

endmodule

// ===== rtl/gaussian_weight_map_eval_unit.sv =====
// Gaussian weight map evaluator: one Q16.16 weight per grid point; uses gwm_pkg, gwm_exp_pipe.
// Pipeline: 46 register stages. Throughput: one point per cycle while the output is not
// stalled; depth is set by the eleven series terms of the exponential,
// three stages each (term multiply, reciprocal multiply, correct and accumulate).
// A stalled output freezes the whole pipeline. Synchronous active-low reset clears all valid
// bits and loads the register defaults (unit peak, unit spreads, 1x1 grid, peak mode).
`include "gaussian_weight_map_eval_unit_defines.svh"

module gaussian_weight_map_eval_unit #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // point channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [COORD_BITS:0]        i_point_x,
    input  logic signed [COORD_BITS:0]        i_point_y,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [gwm_pkg::DATA_W-1:0]        o_weight_value,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gwm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gwm_pkg::DATA_W-1:0]        i_cfg_data
);

    localparam int unsigned CW  = COORD_BITS;
    localparam int unsigned SQW = 2 * COORD_BITS;
    localparam int unsigned TXW = SQW + gwm_pkg::DATA_W;
    localparam int unsigned TW  = TXW + 1;

    // ---------------- configuration ----------------
    logic [CW-1:0]                r_center_x, r_center_y;
    logic [CW:0]                  r_grid_width, r_grid_height;
    logic [gwm_pkg::DATA_W-1:0]   r_spread_x, r_spread_y, r_peak_scale;
    logic                         r_valley_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_grid_width  <= (CW+1)'(1);
            r_grid_height <= (CW+1)'(1);
            r_spread_x    <= gwm_pkg::RST_SPREAD;
            r_spread_y    <= gwm_pkg::RST_SPREAD;
            r_peak_scale  <= gwm_pkg::RST_PEAK;
            r_valley_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (gwm_pkg::t_cfg_idx'(i_cfg_index))
                gwm_pkg::CFG_CENTER_X:    r_center_x    <= i_cfg_data[CW-1:0];
                gwm_pkg::CFG_CENTER_Y:    r_center_y    <= i_cfg_data[CW-1:0];
                gwm_pkg::CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[CW:0];
                gwm_pkg::CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[CW:0];
                gwm_pkg::CFG_SPREAD_X:    r_spread_x    <= i_cfg_data;
                gwm_pkg::CFG_SPREAD_Y:    r_spread_y    <= i_cfg_data;
                gwm_pkg::CFG_PEAK_SCALE:  r_peak_scale  <= i_cfg_data;
                gwm_pkg::CFG_VALLEY_MODE: r_valley_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic r_out_v;
    logic w_en;

    // advance everything unless the output beat is held
    assign w_en    = !r_out_v || !i_stall;
    assign o_stall = !w_en;

    // ---------------- stage 0: grid test and distances ----------------
    logic          w_in_x, w_in_y;
    logic [CW:0]   w_dx, w_dy;
    logic [CW-1:0] w_mx, w_my;

    assign w_in_x = !i_point_x[CW] && ({1'b0, i_point_x[CW-1:0]} < r_grid_width);
    assign w_in_y = !i_point_y[CW] && ({1'b0, i_point_y[CW-1:0]} < r_grid_height);
    assign w_dx   = {1'b0, i_point_x[CW-1:0]} - {1'b0, r_center_x};
    assign w_dy   = {1'b0, i_point_y[CW-1:0]} - {1'b0, r_center_y};
    assign w_mx   = w_dx[CW] ? CW'(-w_dx) : w_dx[CW-1:0];
    assign w_my   = w_dy[CW] ? CW'(-w_dy) : w_dy[CW-1:0];

    logic          r_s0_v, r_s0_in;
    logic [CW-1:0] r_s0_mx, r_s0_my;

    // ---------------- stage 1: squares ----------------
    logic           r_s1_v, r_s1_in;
    logic [SQW-1:0] r_s1_sqx, r_s1_sqy;

    // ---------------- stage 2: scaled squares ----------------
    logic           r_s2_v, r_s2_in;
    logic [TXW-1:0] r_s2_tx, r_s2_ty;

    // ---------------- stage 3: exponent sum ----------------
    logic [TW-1:0]             w_t;
    logic                      r_s3_v;
    logic [gwm_pkg::U_W-1:0]   r_s3_u;
    gwm_pkg::t_exp_tag         r_s3_tag;

    assign w_t = {1'b0, r_s2_tx} + {1'b0, r_s2_ty};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= i_valid;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_in  <= w_in_x && w_in_y;
            r_s0_mx  <= w_mx;
            r_s0_my  <= w_my;
            r_s1_in  <= r_s0_in;
            r_s1_sqx <= {{CW{1'b0}}, r_s0_mx} * {{CW{1'b0}}, r_s0_mx};
            r_s1_sqy <= {{CW{1'b0}}, r_s0_my} * {{CW{1'b0}}, r_s0_my};
            r_s2_in  <= r_s1_in;
            r_s2_tx  <= {{gwm_pkg::DATA_W{1'b0}}, r_s1_sqx} * {{SQW{1'b0}}, r_spread_x};
            r_s2_ty  <= {{gwm_pkg::DATA_W{1'b0}}, r_s1_sqy} * {{SQW{1'b0}}, r_spread_y};
            // the cutoff test sees the unclamped sum; u only matters below it
            r_s3_u           <= {w_t[27:0], 4'd0};
            r_s3_tag.on_grid <= r_s2_in;
            r_s3_tag.big     <= w_t >= TW'(gwm_pkg::T_LIMIT);
        end
    end

    // ---------------- exponential ----------------
    logic                    w_exp_v;
    logic [gwm_pkg::E_W-1:0] w_exp_e;
    gwm_pkg::t_exp_tag       w_exp_tag;

    gwm_exp_pipe u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s3_v),
        .i_u     (r_s3_u),
        .i_tag   (r_s3_tag),
        .o_valid (w_exp_v),
        .o_e     (w_exp_e),
        .o_tag   (w_exp_tag)
    );

    // ---------------- peak scaling and output ----------------
    logic [48:0]                w_g_prod;
    logic                       r_g_v, r_g_in;
    logic [gwm_pkg::DATA_W-1:0] r_g, r_g_peak, r_out;
    logic [gwm_pkg::DATA_W-1:0] w_out;

    assign w_g_prod = {17'd0, r_peak_scale} * {32'd0, w_exp_e};
    assign w_out    = !r_g_in ? '0 : (r_valley_mode ? r_g_peak - r_g : r_g);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_g_v   <= w_exp_v;
            r_out_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g      <= w_g_prod[47:16];
            r_g_peak <= r_peak_scale;
            r_g_in   <= w_exp_tag.on_grid;
            r_out    <= w_out;
        end
    end

    assign o_valid        = r_out_v;
    assign o_weight_value = r_out;

    // ---------------- checks ----------------
    `GWM_ASSERT_IMPLY(a_exp_range, w_exp_v, w_exp_e <= gwm_pkg::E_MAX)
    `GWM_ASSERT_IMPLY(a_g_bound, r_g_v, r_g <= r_g_peak)
    `GWM_ASSERT(a_stall_full, !o_stall || o_valid)

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for gaussian_weight_map_eval_unit: grid points in, Q16.16 weights out.
// Expected weights come from a bit-exact predictor kept here; depends on gwm_pkg and the RTL.
module tb;

    localparam int COORD_BITS = 12;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [63:0] T_CUTOFF = 64'd12 << 24;

    typedef struct {
        logic signed [COORD_BITS:0] x;
        logic signed [COORD_BITS:0] y;
    } t_point;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [COORD_BITS:0] i_point_x = '0;
    logic signed [COORD_BITS:0] i_point_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [gwm_pkg::DATA_W-1:0] o_weight_value;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [gwm_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [gwm_pkg::DATA_W-1:0] i_cfg_data = '0;

    // register mirror
    logic [COORD_BITS-1:0] cfg_cx = '0;
    logic [COORD_BITS-1:0] cfg_cy = '0;
    logic [COORD_BITS:0] cfg_w = 1;
    logic [COORD_BITS:0] cfg_h = 1;
    logic [31:0] cfg_kx = gwm_pkg::RST_SPREAD;
    logic [31:0] cfg_ky = gwm_pkg::RST_SPREAD;
    logic [31:0] cfg_peak = gwm_pkg::RST_PEAK;
    logic cfg_valley = 1'b0;

    t_point points_waiting[$];
    logic [31:0] weights_due[$];

    bit point_taken = 1'b0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int errors = 0;
    int points_sent = 0;
    int weights_checked = 0;
    int weights_nonzero = 0;
    int reg_writes = 0;

    gaussian_weight_map_eval_unit #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_point_x(i_point_x),
        .i_point_y(i_point_y),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_weight_value(o_weight_value),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gaussian weight at one point under the current register mirror
    function automatic logic [31:0] gauss_weight(input logic signed [COORD_BITS:0] px,
                                                 input logic signed [COORD_BITS:0] py);
        longint xi, yi, dx, dy;
        logic [63:0] tsum, u, term, series, p, e, g, r;
        int k;
        xi = longint'(px);
        yi = longint'(py);
        if (xi < 0 || xi >= longint'(cfg_w) || yi < 0 || yi >= longint'(cfg_h))
            return '0;
        dx = xi - longint'(cfg_cx);
        dy = yi - longint'(cfg_cy);
        tsum = 64'(dx * dx) * 64'(cfg_kx) + 64'(dy * dy) * 64'(cfg_ky);
        if (tsum > 64'hFFFF_FFFF)
            tsum = 64'hFFFF_FFFF;
        if (tsum >= T_CUTOFF) begin
            e = '0;
        end else begin
            // e^(-t/16) by series, then raise to the 16th power
            u = tsum << 4;
            series = 64'h1_0000_0000;
            term = 64'h1_0000_0000;
            for (k = 1; k <= 12; k++) begin
                term = (term * u) >> 32;
                term = term / 64'(k);
                if (k % 2 == 1)
                    series = series - term;
                else
                    series = series + term;
            end
            p = (series + 64'd1) >> 1;
            for (k = 0; k < 4; k++)
                p = (p * p + (64'd1 << 30)) >> 31;
            e = (p + (64'd1 << 14)) >> 15;
        end
        g = (64'(cfg_peak) * e) >> 16;
        r = cfg_valley ? 64'(cfg_peak) - g : g;
        return r[31:0];
    endfunction

    // point driver
    always @(negedge i_clk) begin
        if (!i_valid || point_taken) begin
            point_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (!calm && points_waiting.size() > 0 && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 11);
                i_valid <= 1'b0;
            end else if (points_waiting.size() > 0) begin
                i_valid <= 1'b1;
                i_point_x <= points_waiting[0].x;
                i_point_y <= points_waiting[0].y;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // take the accepted point and predict its weight
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            weights_due.push_back(gauss_weight(i_point_x, i_point_y));
            points_waiting.delete(0);
            point_taken = 1'b1;
            points_sent++;
        end
    end

    // result receiver stalls
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (weights_due.size() == 0) begin
                $display("%0t: weight with none expected: actual %h", $time, o_weight_value);
                errors++;
            end else begin
                if (o_weight_value !== weights_due[0]) begin
                    $display("%0t: weight mismatch: expected %h actual %h",
                             $time, weights_due[0], o_weight_value);
                    errors++;
                end
                weights_due.delete(0);
                weights_checked++;
                if (o_weight_value != 0)
                    weights_nonzero++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d weights still due",
                     $time, idle_cycles, weights_due.size());
            $display("gaussian_weight_map_eval_unit test failed");
            $finish;
        end
    end

    task automatic write_reg(input gwm_pkg::t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            gwm_pkg::CFG_CENTER_X:    cfg_cx = value[COORD_BITS-1:0];
            gwm_pkg::CFG_CENTER_Y:    cfg_cy = value[COORD_BITS-1:0];
            gwm_pkg::CFG_GRID_WIDTH:  cfg_w = value[COORD_BITS:0];
            gwm_pkg::CFG_GRID_HEIGHT: cfg_h = value[COORD_BITS:0];
            gwm_pkg::CFG_SPREAD_X:    cfg_kx = value;
            gwm_pkg::CFG_SPREAD_Y:    cfg_ky = value;
            gwm_pkg::CFG_PEAK_SCALE:  cfg_peak = value;
            gwm_pkg::CFG_VALLEY_MODE: cfg_valley = value[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic offer(input int x, input int y);
        t_point pt;
        pt.x = x[COORD_BITS:0];
        pt.y = y[COORD_BITS:0];
        points_waiting.push_back(pt);
    endtask

    task automatic drain();
        while (points_waiting.size() != 0 || weights_due.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_center();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return (1 << COORD_BITS) - 1;
            2: return $urandom;
            default: return $urandom_range(0, (1 << COORD_BITS) - 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 11))
            0: return 0;
            1: return 1;
            2: return 1 << COORD_BITS;
            3: return (1 << (COORD_BITS + 1)) - 1;
            4: return $urandom;
            default: return $urandom_range(1, 1 << COORD_BITS);
        endcase
    endfunction

    function automatic logic [31:0] pick_coeff();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3, 4: return $urandom_range(0, 1 << 26);
            default: return $urandom_range(0, 1 << 20);
        endcase
    endfunction

    initial begin
        int phase, n, span, px, py, lim_w, lim_h, cx, cy;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults: a 1x1 grid holding the peak
        offer(0, 0);
        offer(1, 0);
        offer(0, 1);
        offer(-1, 0);
        offer(-4096, -4096);
        offer(4095, 4095);
        drain();

        // exact cutoff at t = 12 and clamped exponent
        write_reg(gwm_pkg::CFG_CENTER_X, 10);
        write_reg(gwm_pkg::CFG_CENTER_Y, 4095);
        write_reg(gwm_pkg::CFG_GRID_WIDTH, 4096);
        write_reg(gwm_pkg::CFG_GRID_HEIGHT, 4096);
        write_reg(gwm_pkg::CFG_SPREAD_X, 32'd3 << 24);
        write_reg(gwm_pkg::CFG_SPREAD_Y, 32'd1 << 24);
        write_reg(gwm_pkg::CFG_PEAK_SCALE, 32'h0001_0000);
        write_reg(gwm_pkg::CFG_VALLEY_MODE, 0);
        offer(10, 4095);
        offer(12, 4095);
        offer(11, 4095);
        offer(10, 4094);
        offer(0, 0);
        offer(4095, 0);
        drain();

        // valley with full-scale peak, oversized grid width
        write_reg(gwm_pkg::CFG_CENTER_X, 0);
        write_reg(gwm_pkg::CFG_CENTER_Y, 0);
        write_reg(gwm_pkg::CFG_GRID_WIDTH, 8191);
        write_reg(gwm_pkg::CFG_SPREAD_X, 32'hFFFF_FFFF);
        write_reg(gwm_pkg::CFG_SPREAD_Y, 0);
        write_reg(gwm_pkg::CFG_PEAK_SCALE, 32'hFFFF_FFFF);
        write_reg(gwm_pkg::CFG_VALLEY_MODE, 1);
        offer(0, 0);
        offer(0, 4095);
        offer(1, 0);
        offer(-1, 5);
        offer(4095, 4095);
        drain();

        // zero-height grid: nothing lies on it
        write_reg(gwm_pkg::CFG_GRID_HEIGHT, 0);
        write_reg(gwm_pkg::CFG_PEAK_SCALE, 0);
        offer(0, 0);
        offer(5, 5);
        drain();

        for (phase = 0; phase < 9; phase++) begin
            write_reg(gwm_pkg::CFG_CENTER_X, pick_center());
            write_reg(gwm_pkg::CFG_CENTER_Y, pick_center());
            write_reg(gwm_pkg::CFG_GRID_WIDTH, pick_size());
            write_reg(gwm_pkg::CFG_GRID_HEIGHT, pick_size());
            write_reg(gwm_pkg::CFG_SPREAD_X, pick_coeff());
            write_reg(gwm_pkg::CFG_SPREAD_Y, pick_coeff());
            case ($urandom_range(0, 5))
                0: write_reg(gwm_pkg::CFG_PEAK_SCALE, 0);
                1: write_reg(gwm_pkg::CFG_PEAK_SCALE, 32'hFFFF_FFFF);
                2: write_reg(gwm_pkg::CFG_PEAK_SCALE, gwm_pkg::RST_PEAK);
                default: write_reg(gwm_pkg::CFG_PEAK_SCALE, $urandom);
            endcase
            write_reg(gwm_pkg::CFG_VALLEY_MODE, $urandom);
            calm = (phase == 8);
            // fill the pipe while the receiver holds off
            if (phase == 1)
                hold_req = 1'b1;
            lim_w = (cfg_w == 0) ? 1 : ((cfg_w > 4096) ? 4096 : int'(cfg_w));
            lim_h = (cfg_h == 0) ? 1 : ((cfg_h > 4096) ? 4096 : int'(cfg_h));
            cx = int'(cfg_cx);
            cy = int'(cfg_cy);
            for (n = 0; n < 100; n++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        px = $urandom;
                        py = $urandom;
                    end
                    2, 3, 4: begin
                        px = $urandom_range(0, lim_w - 1);
                        py = $urandom_range(0, lim_h - 1);
                    end
                    default: begin
                        case ($urandom_range(0, 2))
                            0: span = 2;
                            1: span = 8;
                            default: span = 32;
                        endcase
                        px = cx + $urandom_range(0, 2 * span) - span;
                        py = cy + $urandom_range(0, 2 * span) - span;
                    end
                endcase
                offer(px, py);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d points and %0d weights (%0d nonzero) over %0d register writes,",
                 points_sent, weights_checked, weights_nonzero, reg_writes);
        $display("including cutoff, clamp, valley, empty-grid and long receiver hold cases.");
        if (errors == 0)
            $display("gaussian_weight_map_eval_unit test passed");
        else
            $display("gaussian_weight_map_eval_unit test failed");
        $finish;
    end
endmodule
